// File: sv/assert_macros.svh
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// File: sv/ple_pkg.sv
package ple_pkg;

	localparam int unsigned ActionW = 2;
	localparam int unsigned PosW    = 5;
	localparam int unsigned ValueW  = 32;
	localparam int unsigned LenW    = 5;

	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 48;

	typedef enum logic [ActionW-1:0] {
		ACT_READ   = 2'd0,
		ACT_LOCATE = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RD,
		ST_EVAL,
		ST_PUT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [LenW-1:0]   length;
		logic [PosW-1:0]   found_position;
		logic [ValueW-1:0] data;
		logic              ok;
	} result_t;

endpackage

// File: sv/ple_store.sv
module ple_store #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned AW       = 4
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [ple_pkg::ValueW-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [ple_pkg::ValueW-1:0] rd_data
);
	import ple_pkg::*;

	logic [ValueW-1:0] mem [CAPACITY];
	logic [ValueW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/ple_ctrl.sv
`include "assert_macros.svh"

module ple_ctrl #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned AW       = 4,
	parameter int unsigned CW       = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ple_pkg::action_t            req_action,
	input  logic [ple_pkg::PosW-1:0]    req_position,
	input  logic [ple_pkg::ValueW-1:0]  req_value,
	output logic                        res_valid,
	input  logic                        res_take,
	output ple_pkg::result_t            res,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [ple_pkg::ValueW-1:0]  wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [ple_pkg::ValueW-1:0]  rd_data
);
	import ple_pkg::*;

	localparam int unsigned CmpW = ((CW > PosW) ? CW : PosW) + 1;

	state_t            state_q, state_d;
	action_t           act_q;
	logic [PosW-1:0]   pos_q;
	logic [ValueW-1:0] val_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     ptr_q;
	logic              first_q;
	logic              ok_q;
	logic [ValueW-1:0] data_q;
	logic [PosW-1:0]   found_q;

	// shared compare unit and pointer arithmetic
	logic          hit;
	logic          at_end;
	logic          at_pos;
	logic [CW-1:0] ptr_inc;
	logic [AW-1:0] pos_idx;
	logic          pos_nz;
	logic          pos_le_cnt;
	logic          pos_le_cnt1;
	logic          not_full;
	logic          rw_ok;
	logic          ins_ok;
	logic          append;

	assign hit         = (rd_data == val_q);
	assign ptr_inc     = CW'(ptr_q) + CW'(1);
	assign at_end      = (ptr_inc == cnt_q);
	assign pos_idx     = AW'(pos_q - PosW'(1));
	assign at_pos      = (ptr_q == pos_idx);
	assign pos_nz      = (pos_q != '0);
	assign pos_le_cnt  = (CmpW'(pos_q) <= CmpW'(cnt_q));
	assign pos_le_cnt1 = (CmpW'(pos_q) <= (CmpW'(cnt_q) + CmpW'(1)));
	assign not_full    = (CmpW'(cnt_q) < CmpW'(CAPACITY));
	assign rw_ok       = pos_nz && pos_le_cnt;
	assign ins_ok      = pos_nz && pos_le_cnt1 && not_full;
	assign append      = (CmpW'(pos_q) == (CmpW'(cnt_q) + CmpW'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				unique case (act_q) inside
					ACT_READ, ACT_DELETE: state_d = rw_ok ? ST_RD : ST_DONE;
					ACT_LOCATE:           state_d = (cnt_q != '0) ? ST_RD : ST_DONE;
					ACT_INSERT: begin
						if (!ins_ok) begin
							state_d = ST_DONE;
						end else if (append) begin
							state_d = ST_PUT;
						end else begin
							state_d = ST_RD;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_RD: state_d = ST_EVAL;
			ST_EVAL: begin
				unique case (act_q)
					ACT_READ:   state_d = ST_DONE;
					ACT_LOCATE: state_d = (hit || at_end) ? ST_DONE : ST_RD;
					ACT_INSERT: state_d = at_pos ? ST_PUT : ST_RD;
					ACT_DELETE: state_d = at_end ? ST_DONE : ST_RD;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_PUT: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = ptr_q;
		wr_data   = rd_data;
		rd_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_RD:   rd_en = 1'b1;
			ST_EVAL: begin
				if (act_q == ACT_INSERT) begin
					wr_en   = 1'b1;
					wr_addr = AW'(ptr_inc);
				end else if (act_q == ACT_DELETE && !first_q) begin
					wr_en   = 1'b1;
					wr_addr = ptr_q - AW'(1);
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_idx;
				wr_data = val_q;
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign rd_addr            = ptr_q;
	assign res.ok             = ok_q;
	assign res.data           = data_q;
	assign res.found_position = found_q;
	assign res.length         = LenW'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PUT) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == ST_EVAL && act_q == ACT_DELETE && at_end) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				act_q   <= req_action;
				pos_q   <= req_position;
				val_q   <= req_value;
				ok_q    <= 1'b0;
				data_q  <= '0;
				found_q <= '0;
				first_q <= 1'b1;
			end
			ST_CHECK: begin
				if (act_q == ACT_LOCATE) begin
					ptr_q <= '0;
				end else if (act_q == ACT_INSERT) begin
					ptr_q <= AW'(cnt_q - CW'(1));
				end else begin
					ptr_q <= pos_idx;
				end
			end
			ST_EVAL: begin
				first_q <= 1'b0;
				unique case (act_q)
					ACT_READ: begin
						data_q <= rd_data;
						ok_q   <= 1'b1;
					end
					ACT_LOCATE: begin
						if (hit) begin
							found_q <= PosW'(ptr_inc);
							ok_q    <= 1'b1;
						end else begin
							ptr_q <= AW'(ptr_inc);
						end
					end
					ACT_INSERT: begin
						ptr_q <= ptr_q - AW'(1);
					end
					ACT_DELETE: begin
						if (first_q) begin
							data_q <= rd_data;
						end
						if (at_end) begin
							ok_q <= 1'b1;
						end else begin
							ptr_q <= AW'(ptr_inc);
						end
					end
					default: ;
				endcase
			end
			ST_PUT: ok_q <= 1'b1;
			default: ;
		endcase
	end

	`ASSERT_NEVER(a_cnt_bound, CmpW'(cnt_q) > CmpW'(CAPACITY), "count above capacity")
	`ASSERT_HOLDS(a_cnt_change, (cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_PUT || $past(state_q) == ST_EVAL), "count moved outside put or delete")
	`ASSERT_HOLDS(a_put_grows, (state_q == ST_PUT) |=> (cnt_q == $past(cnt_q) + CW'(1)), "insert did not grow the list")
	`ASSERT_NEVER(a_wr_range, wr_en && (CmpW'(wr_addr) > CmpW'(cnt_q)), "write beyond list end")

endmodule

// File: sv/positional_list_engine_core.sv
// channel | dir | tdata fields, lowest bit up
// s_*     | in  | action[1:0] position[6:2] value[38:7], zero pad to 40
// m_*     | out | ok[0] data[32:1] found_position[37:33] length[42:38], zero pad to 48
//
// after the input transfer the sequencer runs check, then read and evaluate for each entry visited, then done;
// a rejected request or a locate on an empty list goes from check to done; locate scans from the front to a hit
// or the end, insert shifts entries up from the back then puts the value, delete shifts entries down to the end
// the sequencer holds s_tready low from the input transfer until its result is
// placed in the output register, which then waits for m_tready on its own
// reset clears the length and the handshake; list storage is not cleared

module positional_list_engine_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ple_pkg::InDataW-1:0]    s_tdata,  // action, position, value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ple_pkg::OutDataW-1:0]   m_tdata   // ok, data, found_position, length
);
	import ple_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic              res_valid;
	logic              res_take;
	result_t           res;
	result_t           res_q;
	logic              m_tvalid_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ValueW-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [ValueW-1:0] rd_data;

	ple_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (s_tvalid),
		.req_ready    (s_tready),
		.req_action   (action_t'(s_tdata[1:0])),
		.req_position (s_tdata[6:2]),
		.req_value    (s_tdata[38:7]),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	ple_store #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result moves into the output register once it is empty or being drained
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, res_q.length, res_q.found_position, res_q.data, res_q.ok};

	logic unused_pad;
	assign unused_pad = s_tdata[39];

endmodule
